// ===== sv/tnid_pkg.sv =====
// Shared types and constants of the newline and indentation detector.
`default_nettype none
package tnid_pkg;

  // Configuration port geometry.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Fixed field widths.
  localparam int unsigned CP_W        = 22;
  localparam int unsigned BYTES_W     = 3;
  localparam int unsigned LIMIT_W     = 25;
  localparam int unsigned SPACE_RUN_W = 8;

  // Characters that matter to the scan.
  localparam logic [CP_W-1:0] CH_NUL   = 22'd0;
  localparam logic [CP_W-1:0] CH_TAB   = 22'd9;
  localparam logic [CP_W-1:0] CH_LF    = 22'd10;
  localparam logic [CP_W-1:0] CH_CR    = 22'd13;
  localparam logic [CP_W-1:0] CH_SPACE = 22'd32;

  localparam logic [SPACE_RUN_W-1:0] MIN_WIDTH_RESET = 8'd8;
  localparam logic [SPACE_RUN_W-1:0] SPACE_RUN_MAX   = 8'd255;

  // Register reset values.
  localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RESET  = 25'd1048576;
  localparam logic [7:0]         PRIOR_WIDTH_RESET = 8'd4;

  typedef enum logic [2:0] {
    REG_SCAN_LIMIT     = 3'd0,
    REG_FORCED_NEWLINE = 3'd1,
    REG_FORCED_INDENT  = 3'd2,
    REG_FORCED_WIDTH   = 3'd3,
    REG_PRIOR_WIDTH    = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    NL_AUTO = 2'd0,
    NL_LF   = 2'd1,
    NL_CR   = 2'd2,
    NL_CRLF = 2'd3
  } newline_e;

  // Indent kind of one line, and the reported indent style.
  typedef enum logic [1:0] {
    IND_NONE  = 2'd0,
    IND_TAB   = 2'd1,
    IND_SPACE = 2'd2,
    IND_MIXED = 2'd3
  } indent_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] scan_limit;
    logic [1:0]         forced_newline;
    logic [1:0]         forced_indent;
    logic [7:0]         forced_width;
    logic [7:0]         prior_width;
  } cfg_t;

endpackage
`default_nettype wire

// ===== sv/text_newline_indent_detector.sv =====
// Top level of the newline and indentation detector.
//
// The block takes one decoded character per transfer (codepoint, its byte length in
// the source, and a flag on the last character of the document) and accepts a new
// character in every clock cycle. It counts CR, LF and CRLF line ends, classifies each
// line's leading whitespace as tab, space or mixed, and keeps the shortest nonzero
// leading space run (starting from 8). Characters are ignored after two NULs in a row
// (a NUL as the first character counts as following one) and once the byte offset
// reaches scan_limit. The final character produces exactly one result: newline style,
// indent style and indent width by threefold-majority rules, with the forced_* register
// overrides applied; the scan state then returns to its reset value for the next
// document. Other characters produce no result. The scan state behind the input
// register is updated once per character. A result passes from the input register
// through the snapshot register into the output register and is held until taken.
// Meanwhile further characters are still accepted. The snapshot register behind the
// scan holds the counts of one more document, so the input stalls only when a third
// final character reaches the scan while an untaken result and a pending snapshot
// are both ahead of it.
`default_nettype none
module text_newline_indent_detector #(
  parameter int unsigned COUNT_BITS = 25
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Character stream.
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [tnid_pkg::CP_W-1:0]        codepoint_i,
  input  wire logic [tnid_pkg::BYTES_W-1:0]     byte_count_i,
  input  wire logic                             final_item_i,
  // Result stream.
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [1:0]                       newline_style_o,
  output logic      [1:0]                       indent_style_o,
  output logic      [7:0]                       indent_width_o,
  // Configuration port.
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tnid_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [tnid_pkg::DATA_W-1:0]      pwdata,
  output logic      [tnid_pkg::DATA_W-1:0]      prdata,
  output logic                                  pready
);

  tnid_pkg::cfg_t                   cfg;
  logic                             snap_valid;
  logic                             snap_ready;
  logic [COUNT_BITS-1:0]            snap_cr, snap_lf, snap_crlf, snap_tab, snap_space;
  logic [tnid_pkg::SPACE_RUN_W-1:0] snap_min_width;

  // Register file; the user must write it only while no document is in flight, which the block does not enforce.
  tnid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register and scan state. On the final character it hands the updated
  // counts over as a snapshot and clears itself in the same cycle.
  tnid_scan #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .codepoint_i      (codepoint_i),
    .byte_count_i     (byte_count_i),
    .final_item_i     (final_item_i),
    .cfg_i            (cfg),
    .snap_ready_i     (snap_ready),
    .snap_valid_o     (snap_valid),
    .snap_cr_o        (snap_cr),
    .snap_lf_o        (snap_lf),
    .snap_crlf_o      (snap_crlf),
    .snap_tab_o       (snap_tab),
    .snap_space_o     (snap_space),
    .snap_min_width_o (snap_min_width)
  );

  // Snapshot register, majority decision and result register.
  tnid_decide #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decide (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .snap_valid_i     (snap_valid),
    .snap_ready_o     (snap_ready),
    .snap_cr_i        (snap_cr),
    .snap_lf_i        (snap_lf),
    .snap_crlf_i      (snap_crlf),
    .snap_tab_i       (snap_tab),
    .snap_space_i     (snap_space),
    .snap_min_width_i (snap_min_width),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .newline_style_o  (newline_style_o),
    .indent_style_o   (indent_style_o),
    .indent_width_o   (indent_width_o)
  );

endmodule
`default_nettype wire

// ===== sv/tnid_regs.sv =====
// Configuration registers of the detector behind an APB-style port.
`default_nettype none
module tnid_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tnid_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tnid_pkg::DATA_W-1:0]  pwdata,
  output logic      [tnid_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output tnid_pkg::cfg_t                    cfg_o
);

  tnid_pkg::cfg_t   cfg_q;
  tnid_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = tnid_pkg::reg_idx_e'(paddr[tnid_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scan_limit     <= tnid_pkg::SCAN_LIMIT_RESET;
      cfg_q.forced_newline <= 2'd0;
      cfg_q.forced_indent  <= 2'd0;
      cfg_q.forced_width   <= 8'd0;
      cfg_q.prior_width    <= tnid_pkg::PRIOR_WIDTH_RESET;
    end else if (wr_en) begin
      case (idx)
        tnid_pkg::REG_SCAN_LIMIT:     cfg_q.scan_limit <= pwdata[tnid_pkg::LIMIT_W-1:0];
        tnid_pkg::REG_FORCED_NEWLINE: cfg_q.forced_newline <= pwdata[1:0];
        tnid_pkg::REG_FORCED_INDENT:  cfg_q.forced_indent <= pwdata[1:0];
        tnid_pkg::REG_FORCED_WIDTH:   cfg_q.forced_width <= pwdata[7:0];
        tnid_pkg::REG_PRIOR_WIDTH:    cfg_q.prior_width <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      tnid_pkg::REG_SCAN_LIMIT:     prdata = tnid_pkg::DATA_W'(cfg_q.scan_limit);
      tnid_pkg::REG_FORCED_NEWLINE: prdata = tnid_pkg::DATA_W'(cfg_q.forced_newline);
      tnid_pkg::REG_FORCED_INDENT:  prdata = tnid_pkg::DATA_W'(cfg_q.forced_indent);
      tnid_pkg::REG_FORCED_WIDTH:   prdata = tnid_pkg::DATA_W'(cfg_q.forced_width);
      tnid_pkg::REG_PRIOR_WIDTH:    prdata = tnid_pkg::DATA_W'(cfg_q.prior_width);
      default:                      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/tnid_scan.sv =====
// Input register and per-character scan state: line ends, indentation, byte offset.
`default_nettype none
module tnid_scan #(
  parameter int unsigned COUNT_BITS = 25
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [tnid_pkg::CP_W-1:0]        codepoint_i,
  input  wire logic [tnid_pkg::BYTES_W-1:0]     byte_count_i,
  input  wire logic                             final_item_i,
  input  wire tnid_pkg::cfg_t                   cfg_i,
  input  wire logic                             snap_ready_i,
  output logic                                  snap_valid_o,
  output logic      [COUNT_BITS-1:0]            snap_cr_o,
  output logic      [COUNT_BITS-1:0]            snap_lf_o,
  output logic      [COUNT_BITS-1:0]            snap_crlf_o,
  output logic      [COUNT_BITS-1:0]            snap_tab_o,
  output logic      [COUNT_BITS-1:0]            snap_space_o,
  output logic      [tnid_pkg::SPACE_RUN_W-1:0] snap_min_width_o
);

  localparam int unsigned CMP_W =
      (COUNT_BITS > tnid_pkg::LIMIT_W) ? COUNT_BITS : tnid_pkg::LIMIT_W;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  // Input register.
  logic                         a_valid_q;
  logic [tnid_pkg::CP_W-1:0]    a_cp_q;
  logic [tnid_pkg::BYTES_W-1:0] a_bytes_q;
  logic                         a_final_q;
  logic                         a_go;

  // Scan state. Only two facts about the previous character are ever needed.
  logic                             prev_cr_q, prev_cr_d;
  logic                             prev_nul_q, prev_nul_d;
  logic                             line_start_q, line_start_d;
  logic [tnid_pkg::SPACE_RUN_W-1:0] space_run_q, space_run_d;
  tnid_pkg::indent_e                kind_q, kind_d;
  logic [COUNT_BITS-1:0]            cr_q, cr_d;
  logic [COUNT_BITS-1:0]            lf_q, lf_d;
  logic [COUNT_BITS-1:0]            crlf_q, crlf_d;
  logic [COUNT_BITS-1:0]            tab_q, tab_d;
  logic [COUNT_BITS-1:0]            space_q, space_d;
  logic [tnid_pkg::SPACE_RUN_W-1:0] min_width_q, min_width_d;
  logic [COUNT_BITS-1:0]            offset_q, offset_d;
  logic                             halted_q, halted_d;

  logic                  active;
  logic                  is_tab, is_space, is_cr, is_lf, is_nul;
  logic [CMP_W-1:0]      off_ext, lim_ext;
  logic [COUNT_BITS:0]   off_sum;

  assign a_go        = a_valid_q && (!a_final_q || snap_ready_i);
  assign in_ready_o  = !a_valid_q || a_go;
  assign snap_valid_o = a_go && a_final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_cp_q    <= codepoint_i;
      a_bytes_q <= byte_count_i;
      a_final_q <= final_item_i;
    end
  end

  assign is_tab   = (a_cp_q == tnid_pkg::CH_TAB);
  assign is_space = (a_cp_q == tnid_pkg::CH_SPACE);
  assign is_cr    = (a_cp_q == tnid_pkg::CH_CR);
  assign is_lf    = (a_cp_q == tnid_pkg::CH_LF);
  assign is_nul   = (a_cp_q == tnid_pkg::CH_NUL);

  assign off_ext = CMP_W'(offset_q);
  assign lim_ext = CMP_W'(cfg_i.scan_limit);
  assign active  = !halted_q && (off_ext < lim_ext);
  assign off_sum = {1'b0, offset_q} + (COUNT_BITS + 1)'(a_bytes_q);

  always_comb begin
    prev_cr_d    = prev_cr_q;
    prev_nul_d   = prev_nul_q;
    line_start_d = line_start_q;
    space_run_d  = space_run_q;
    kind_d       = kind_q;
    cr_d         = cr_q;
    lf_d         = lf_q;
    crlf_d       = crlf_q;
    tab_d        = tab_q;
    space_d      = space_q;
    min_width_d  = min_width_q;
    offset_d     = offset_q;
    halted_d     = halted_q;

    if (active) begin
      if (prev_nul_q && is_nul) begin
        halted_d = 1'b1;
      end else begin
        if (is_tab && line_start_q) begin
          kind_d = (kind_q == tnid_pkg::IND_NONE || kind_q == tnid_pkg::IND_TAB)
                   ? tnid_pkg::IND_TAB : tnid_pkg::IND_MIXED;
        end else if (is_space && line_start_q) begin
          kind_d = (kind_q == tnid_pkg::IND_NONE || kind_q == tnid_pkg::IND_SPACE)
                   ? tnid_pkg::IND_SPACE : tnid_pkg::IND_MIXED;
          if (space_run_q != tnid_pkg::SPACE_RUN_MAX) begin
            space_run_d = space_run_q + 8'd1;
          end
        end else if (is_cr || is_lf) begin
          if (kind_q == tnid_pkg::IND_TAB) begin
            tab_d = sat_inc(tab_q);
          end else if (kind_q == tnid_pkg::IND_SPACE) begin
            space_d = sat_inc(space_q);
            if (space_run_q != 8'd0 && space_run_q < min_width_q) begin
              min_width_d = space_run_q;
            end
          end
          line_start_d = 1'b1;
          space_run_d  = 8'd0;
          kind_d       = tnid_pkg::IND_NONE;
        end else begin
          line_start_d = 1'b0;
        end

        // A CR is counted only once the next character shows whether an LF follows.
        if (prev_cr_q) begin
          if (is_lf) begin
            crlf_d = sat_inc(crlf_q);
          end else begin
            cr_d = sat_inc(cr_q);
          end
        end else if (is_lf) begin
          lf_d = sat_inc(lf_q);
        end

        prev_cr_d  = is_cr;
        prev_nul_d = is_nul;
        offset_d   = off_sum[COUNT_BITS] ? '1 : off_sum[COUNT_BITS-1:0];
      end
    end
  end

  assign snap_cr_o        = cr_d;
  assign snap_lf_o        = lf_d;
  assign snap_crlf_o      = crlf_d;
  assign snap_tab_o       = tab_d;
  assign snap_space_o     = space_d;
  assign snap_min_width_o = min_width_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cr_q    <= 1'b0;
      prev_nul_q   <= 1'b1;
      line_start_q <= 1'b1;
      space_run_q  <= '0;
      kind_q       <= tnid_pkg::IND_NONE;
      cr_q         <= '0;
      lf_q         <= '0;
      crlf_q       <= '0;
      tab_q        <= '0;
      space_q      <= '0;
      min_width_q  <= tnid_pkg::MIN_WIDTH_RESET;
      offset_q     <= '0;
      halted_q     <= 1'b0;
    end else if (a_go) begin
      if (a_final_q) begin
        // The document ends here: start the next one from a clean state.
        prev_cr_q    <= 1'b0;
        prev_nul_q   <= 1'b1;
        line_start_q <= 1'b1;
        space_run_q  <= '0;
        kind_q       <= tnid_pkg::IND_NONE;
        cr_q         <= '0;
        lf_q         <= '0;
        crlf_q       <= '0;
        tab_q        <= '0;
        space_q      <= '0;
        min_width_q  <= tnid_pkg::MIN_WIDTH_RESET;
        offset_q     <= '0;
        halted_q     <= 1'b0;
      end else begin
        prev_cr_q    <= prev_cr_d;
        prev_nul_q   <= prev_nul_d;
        line_start_q <= line_start_d;
        space_run_q  <= space_run_d;
        kind_q       <= kind_d;
        cr_q         <= cr_d;
        lf_q         <= lf_d;
        crlf_q       <= crlf_d;
        tab_q        <= tab_d;
        space_q      <= space_d;
        min_width_q  <= min_width_d;
        offset_q     <= offset_d;
        halted_q     <= halted_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/tnid_decide.sv =====
// Snapshot register and majority decision with user overrides into the result register.
`default_nettype none
module tnid_decide #(
  parameter int unsigned COUNT_BITS = 25
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire tnid_pkg::cfg_t                   cfg_i,
  input  wire logic                             snap_valid_i,
  output logic                                  snap_ready_o,
  input  wire logic [COUNT_BITS-1:0]            snap_cr_i,
  input  wire logic [COUNT_BITS-1:0]            snap_lf_i,
  input  wire logic [COUNT_BITS-1:0]            snap_crlf_i,
  input  wire logic [COUNT_BITS-1:0]            snap_tab_i,
  input  wire logic [COUNT_BITS-1:0]            snap_space_i,
  input  wire logic [tnid_pkg::SPACE_RUN_W-1:0] snap_min_width_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [1:0]                       newline_style_o,
  output logic      [1:0]                       indent_style_o,
  output logic      [7:0]                       indent_width_o
);

  localparam int unsigned W = COUNT_BITS + 3;

  // True when a exceeds three times the sum of b and c.
  function automatic logic over_three(input logic [COUNT_BITS-1:0] a,
                                      input logic [COUNT_BITS-1:0] b,
                                      input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS:0] s;
    logic [W-1:0]        t;
    s = {1'b0, b} + {1'b0, c};
    t = W'({s, 1'b0}) + W'(s);
    return W'(a) > t;
  endfunction

  logic                             b_valid_q;
  logic [COUNT_BITS-1:0]            b_cr_q, b_lf_q, b_crlf_q, b_tab_q, b_space_q;
  logic [tnid_pkg::SPACE_RUN_W-1:0] b_min_width_q;
  logic                             b_move;

  logic                             c_valid_q;
  logic                             c_load;
  logic [1:0]                       c_nl_q, c_style_q;
  logic [7:0]                       c_width_q;

  tnid_pkg::newline_e nl_d;
  tnid_pkg::indent_e  style_d;
  logic [7:0]         width_d;

  assign c_load       = !c_valid_q || out_ready_i;
  assign b_move       = b_valid_q && c_load;
  assign snap_ready_o = !b_valid_q || b_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (snap_ready_o) begin
        b_valid_q <= snap_valid_i;
      end
      if (c_load) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_ready_o && snap_valid_i) begin
      b_cr_q        <= snap_cr_i;
      b_lf_q        <= snap_lf_i;
      b_crlf_q      <= snap_crlf_i;
      b_tab_q       <= snap_tab_i;
      b_space_q     <= snap_space_i;
      b_min_width_q <= snap_min_width_i;
    end
    if (b_move) begin
      c_nl_q    <= nl_d;
      c_style_q <= style_d;
      c_width_q <= width_d;
    end
  end

  always_comb begin
    if (over_three(b_crlf_q, b_cr_q, b_lf_q)) begin
      nl_d = tnid_pkg::NL_CRLF;
    end else if (over_three(b_cr_q, b_crlf_q, b_lf_q)) begin
      nl_d = tnid_pkg::NL_CR;
    end else if (over_three(b_lf_q, b_crlf_q, b_cr_q)) begin
      nl_d = tnid_pkg::NL_LF;
    end else begin
      nl_d = tnid_pkg::NL_AUTO;
    end
    if (cfg_i.forced_newline != 2'd0) begin
      nl_d = tnid_pkg::newline_e'(cfg_i.forced_newline);
    end

    width_d = (cfg_i.prior_width == 8'd0) ? 8'd1 : cfg_i.prior_width;
    if (over_three(b_tab_q, b_space_q, '0)) begin
      style_d = tnid_pkg::IND_TAB;
    end else if (over_three(b_space_q, b_tab_q, '0)) begin
      style_d = tnid_pkg::IND_SPACE;
      width_d = b_min_width_q;
    end else begin
      style_d = tnid_pkg::IND_NONE;
    end
    if (cfg_i.forced_indent == tnid_pkg::IND_TAB || cfg_i.forced_indent == tnid_pkg::IND_SPACE) begin
      style_d = tnid_pkg::indent_e'(cfg_i.forced_indent);
    end
    if (cfg_i.forced_width != 8'd0) begin
      width_d = cfg_i.forced_width;
    end
  end

  assign out_valid_o     = c_valid_q;
  assign newline_style_o = c_nl_q;
  assign indent_style_o  = c_style_q;
  assign indent_width_o  = c_width_q;

endmodule
`default_nettype wire

// ===== dv/tb_text_newline_indent_detector.sv =====
// Self-checking testbench for the newline and indentation detector.
`timescale 1ns / 1ps
module tb_text_newline_indent_detector;

  localparam int unsigned COUNT_W      = 25;
  localparam int unsigned RESET_CYCLES = 11;
  // A result passes the snapshot and output registers after the final transfer; leave some slack.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 500000;
  // Least number of characters sent per random register setting.
  localparam int unsigned SEG_CHARS    = 35;

  // One character of a document as it is sent to the block.
  typedef struct {
    logic [tnid_pkg::CP_W-1:0]    cp;
    logic [tnid_pkg::BYTES_W-1:0] nbytes;
  } char_t;

  // One style report, as the block should produce it on a final character.
  typedef struct {
    tnid_pkg::newline_e nl;
    tnid_pkg::indent_e  ind;
    logic [7:0]         width;
  } style_rpt_t;

  // Running scan state of the current document.
  typedef struct {
    logic [tnid_pkg::CP_W-1:0]        prev_cp;
    bit                               at_start;
    logic [tnid_pkg::SPACE_RUN_W-1:0] run;
    tnid_pkg::indent_e                kind;
    logic [COUNT_W-1:0]               n_cr;
    logic [COUNT_W-1:0]               n_lf;
    logic [COUNT_W-1:0]               n_crlf;
    logic [COUNT_W-1:0]               tab_lines;
    logic [COUNT_W-1:0]               space_lines;
    logic [tnid_pkg::SPACE_RUN_W-1:0] min_w;
    logic [COUNT_W-1:0]               offset;
    bit                               halted;
  } scan_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         in_valid_i   = 1'b0;
  logic                         in_ready_o;
  logic [tnid_pkg::CP_W-1:0]    codepoint_i  = '0;
  logic [tnid_pkg::BYTES_W-1:0] byte_count_i = 3'd1;
  logic                         final_item_i = 1'b0;

  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] newline_style_o;
  logic [1:0] indent_style_o;
  logic [7:0] indent_width_o;

  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [tnid_pkg::ADDR_W-1:0] paddr   = '0;
  logic [tnid_pkg::DATA_W-1:0] pwdata  = '0;
  logic [tnid_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  // Shadow of the configuration registers, kept in step with every APB write.
  tnid_pkg::cfg_t regs = '{scan_limit: tnid_pkg::SCAN_LIMIT_RESET, forced_newline: 2'd0,
                           forced_indent: 2'd0, forced_width: 8'd0,
                           prior_width: tnid_pkg::PRIOR_WIDTH_RESET};
  scan_t scan;

  style_rpt_t expected_styles[$];
  char_t      doc_q[$];

  int unsigned chars_sent    = 0;
  int unsigned mismatches    = 0;
  int unsigned cycles        = 0;
  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;

  text_newline_indent_detector #(
    .COUNT_BITS(COUNT_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .codepoint_i    (codepoint_i),
    .byte_count_i   (byte_count_i),
    .final_item_i   (final_item_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .newline_style_o(newline_style_o),
    .indent_style_o (indent_style_o),
    .indent_width_o (indent_width_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction. The scan state mirrors what the block keeps per document; the
  // style report is formed on the final character and the state then starts over.
  // ---------------------------------------------------------------------------

  function automatic logic [COUNT_W-1:0] sat_count(logic [COUNT_W-1:0] a,
                                                   logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  endfunction

  function automatic void clear_scan();
    scan.prev_cp     = tnid_pkg::CH_NUL;
    scan.at_start    = 1'b1;
    scan.run         = '0;
    scan.kind        = tnid_pkg::IND_NONE;
    scan.n_cr        = '0;
    scan.n_lf        = '0;
    scan.n_crlf      = '0;
    scan.tab_lines   = '0;
    scan.space_lines = '0;
    scan.min_w       = tnid_pkg::MIN_WIDTH_RESET;
    scan.offset      = '0;
    scan.halted      = 1'b0;
  endfunction

  // Line bookkeeping for one character that was not dropped by the scan stop.
  function automatic void take_char(logic [tnid_pkg::CP_W-1:0] cp);
    if (cp == tnid_pkg::CH_TAB && scan.at_start) begin
      scan.kind = (scan.kind == tnid_pkg::IND_NONE || scan.kind == tnid_pkg::IND_TAB)
                  ? tnid_pkg::IND_TAB : tnid_pkg::IND_MIXED;
    end else if (cp == tnid_pkg::CH_SPACE && scan.at_start) begin
      scan.kind = (scan.kind == tnid_pkg::IND_NONE || scan.kind == tnid_pkg::IND_SPACE)
                  ? tnid_pkg::IND_SPACE : tnid_pkg::IND_MIXED;
      if (scan.run != tnid_pkg::SPACE_RUN_MAX) scan.run = scan.run + 1'b1;
    end else if (cp == tnid_pkg::CH_CR || cp == tnid_pkg::CH_LF) begin
      // The line just ended: count it by the kind of its leading whitespace.
      if (scan.kind == tnid_pkg::IND_TAB) begin
        scan.tab_lines = sat_count(scan.tab_lines, 25'd1);
      end else if (scan.kind == tnid_pkg::IND_SPACE) begin
        scan.space_lines = sat_count(scan.space_lines, 25'd1);
        if (scan.run != 0 && scan.run < scan.min_w) scan.min_w = scan.run;
      end
      scan.at_start = 1'b1;
      scan.run      = '0;
      scan.kind     = tnid_pkg::IND_NONE;
    end else begin
      scan.at_start = 1'b0;
    end

    // A CR is only classified once the next character shows whether an LF follows,
    // so a CR at the very end of a document is never counted.
    if (scan.prev_cp == tnid_pkg::CH_CR) begin
      if (cp == tnid_pkg::CH_LF) scan.n_crlf = sat_count(scan.n_crlf, 25'd1);
      else                       scan.n_cr   = sat_count(scan.n_cr, 25'd1);
    end else if (cp == tnid_pkg::CH_LF) begin
      scan.n_lf = sat_count(scan.n_lf, 25'd1);
    end
    scan.prev_cp = cp;
  endfunction

  // Threefold-majority decision, then the register overrides.
  function automatic style_rpt_t final_report();
    style_rpt_t r;
    longint unsigned cr, lf, crlf, tabs, spaces;
    cr     = scan.n_cr;
    lf     = scan.n_lf;
    crlf   = scan.n_crlf;
    tabs   = scan.tab_lines;
    spaces = scan.space_lines;

    if (crlf > (cr + lf) * 3)      r.nl = tnid_pkg::NL_CRLF;
    else if (cr > (crlf + lf) * 3) r.nl = tnid_pkg::NL_CR;
    else if (lf > (crlf + cr) * 3) r.nl = tnid_pkg::NL_LF;
    else                           r.nl = tnid_pkg::NL_AUTO;
    if (regs.forced_newline != tnid_pkg::NL_AUTO)
      r.nl = tnid_pkg::newline_e'(regs.forced_newline);

    r.width = (regs.prior_width == 8'd0) ? 8'd1 : regs.prior_width;
    if (tabs > spaces * 3) begin
      r.ind = tnid_pkg::IND_TAB;
    end else if (spaces > tabs * 3) begin
      r.ind   = tnid_pkg::IND_SPACE;
      r.width = scan.min_w;
    end else begin
      r.ind = tnid_pkg::IND_NONE;
    end
    // Only tab and space count as an indent override; the fourth code is ignored.
    if (regs.forced_indent == tnid_pkg::IND_TAB || regs.forced_indent == tnid_pkg::IND_SPACE)
      r.ind = tnid_pkg::indent_e'(regs.forced_indent);
    if (regs.forced_width != 8'd0) r.width = regs.forced_width;
    return r;
  endfunction

  // Called once per accepted character transfer.
  function automatic void scan_char(logic [tnid_pkg::CP_W-1:0] cp,
                                    logic [tnid_pkg::BYTES_W-1:0] nbytes, bit fin);
    if (!scan.halted && scan.offset < regs.scan_limit) begin
      // A NUL right after a NUL stops the scan; previous starts out as NUL.
      if (scan.prev_cp == tnid_pkg::CH_NUL && cp == tnid_pkg::CH_NUL) begin
        scan.halted = 1'b1;
      end else begin
        take_char(cp);
        scan.offset = sat_count(scan.offset, COUNT_W'(nbytes));
      end
    end
    if (fin) begin
      expected_styles.push_back(final_report());
      clear_scan();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving. Inputs change on the falling edge; handshakes are judged on the
  // rising edge, where the block's registered outputs still hold their old values.
  // ---------------------------------------------------------------------------

  task automatic send_char(logic [tnid_pkg::CP_W-1:0] cp,
                           logic [tnid_pkg::BYTES_W-1:0] nbytes, bit fin);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    codepoint_i  <= cp;
    byte_count_i <= nbytes;
    final_item_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    chars_sent++;
    scan_char(cp, nbytes, fin);
  endtask

  task automatic add_char(logic [tnid_pkg::CP_W-1:0] cp, logic [tnid_pkg::BYTES_W-1:0] nbytes);
    doc_q.push_back('{cp: cp, nbytes: nbytes});
  endtask

  // Sends the queued document, marking its last character as final.
  task automatic send_doc();
    if (doc_q.size() == 0) add_char(tnid_pkg::CP_W'("z"), 3'd1);
    foreach (doc_q[i]) send_char(doc_q[i].cp, doc_q[i].nbytes, i == doc_q.size() - 1);
    doc_q.delete();
  endtask

  // Drops valid, then waits until every report is in and the block has settled.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_styles.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(tnid_pkg::reg_idx_e idx, logic [tnid_pkg::DATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      tnid_pkg::REG_SCAN_LIMIT:     regs.scan_limit     = val[tnid_pkg::LIMIT_W-1:0];
      tnid_pkg::REG_FORCED_NEWLINE: regs.forced_newline = val[1:0];
      tnid_pkg::REG_FORCED_INDENT:  regs.forced_indent  = val[1:0];
      tnid_pkg::REG_FORCED_WIDTH:   regs.forced_width   = val[7:0];
      tnid_pkg::REG_PRIOR_WIDTH:    regs.prior_width    = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Rewrites all registers; only done with the block idle.
  task automatic program_regs(logic [tnid_pkg::LIMIT_W-1:0] limit, logic [1:0] nl,
                              logic [1:0] ind, logic [7:0] fwidth, logic [7:0] pwidth);
    wait_drained();
    write_reg(tnid_pkg::REG_SCAN_LIMIT,     tnid_pkg::DATA_W'(limit));
    write_reg(tnid_pkg::REG_FORCED_NEWLINE, tnid_pkg::DATA_W'(nl));
    write_reg(tnid_pkg::REG_FORCED_INDENT,  tnid_pkg::DATA_W'(ind));
    write_reg(tnid_pkg::REG_FORCED_WIDTH,   tnid_pkg::DATA_W'(fwidth));
    write_reg(tnid_pkg::REG_PRIOR_WIDTH,    tnid_pkg::DATA_W'(pwidth));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and an in-order check of every report.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= take_idle_pct);

  always @(posedge clk_i) begin : check_reports
    style_rpt_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_styles.size() == 0) begin
        report_mismatch("style report with no document pending");
      end else begin
        want = expected_styles.pop_front();
        if (newline_style_o !== want.nl)
          report_mismatch($sformatf("newline_style %0d, predicted %0d",
                                    newline_style_o, want.nl));
        if (indent_style_o !== want.ind)
          report_mismatch($sformatf("indent_style %0d, predicted %0d",
                                    indent_style_o, want.ind));
        if (indent_width_o !== want.width)
          report_mismatch($sformatf("indent_width %0d, predicted %0d",
                                    indent_width_o, want.width));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("text_newline_indent_detector verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Random document content.
  // ---------------------------------------------------------------------------

  // Mostly legal lengths, now and then a length outside one to four.
  function automatic logic [tnid_pkg::BYTES_W-1:0] random_bytes();
    if ($urandom_range(99) < 95) return tnid_pkg::BYTES_W'($urandom_range(1, 4));
    return tnid_pkg::BYTES_W'($urandom_range(0, 7));
  endfunction

  function automatic logic [tnid_pkg::CP_W-1:0] body_char();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) return tnid_pkg::CP_W'($urandom_range(33, 126));
    if (pick < 85) return '1;  // undecodable sequence
    if (pick < 87) return tnid_pkg::CH_NUL;
    return tnid_pkg::CP_W'($urandom_range(127, 1114111));
  endfunction

  // Characters dense in line ends, whitespace and NULs.
  function automatic logic [tnid_pkg::CP_W-1:0] noise_char();
    case ($urandom_range(0, 7))
      0: return tnid_pkg::CH_NUL;
      1: return tnid_pkg::CH_TAB;
      2: return tnid_pkg::CH_LF;
      3: return tnid_pkg::CH_CR;
      4: return tnid_pkg::CH_SPACE;
      5: return '1;
      default: return body_char();
    endcase
  endfunction

  // Line end in the document's preferred style most of the time.
  task automatic add_line_end(tnid_pkg::newline_e pref);
    tnid_pkg::newline_e style;
    style = pref;
    if (style == tnid_pkg::NL_AUTO || $urandom_range(99) < 15)
      style = tnid_pkg::newline_e'($urandom_range(1, 3));
    case (style)
      tnid_pkg::NL_LF: add_char(tnid_pkg::CH_LF, random_bytes());
      tnid_pkg::NL_CR: add_char(tnid_pkg::CH_CR, random_bytes());
      default: begin
        add_char(tnid_pkg::CH_CR, random_bytes());
        add_char(tnid_pkg::CH_LF, random_bytes());
      end
    endcase
  endtask

  // Most documents are well-formed lines with a dominant newline and indent style
  // so that the majority rules fire; the rest is unstructured noise.
  task automatic send_random_doc();
    int unsigned        lines, unit, depth;
    tnid_pkg::newline_e nl_pref;
    tnid_pkg::indent_e  ind_pref, kind;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 30)) add_char(noise_char(), random_bytes());
    end else begin
      nl_pref  = tnid_pkg::newline_e'($urandom_range(0, 3));
      ind_pref = tnid_pkg::indent_e'($urandom_range(0, 3));
      unit     = $urandom_range(1, 8);
      lines    = $urandom_range(1, 6);
      for (int l = 0; l < lines; l++) begin
        kind  = ($urandom_range(99) < 80) ? ind_pref : tnid_pkg::indent_e'($urandom_range(0, 3));
        depth = $urandom_range(0, 3);
        case (kind)
          tnid_pkg::IND_TAB:   repeat (depth) add_char(tnid_pkg::CH_TAB, random_bytes());
          tnid_pkg::IND_SPACE: repeat (depth * unit) add_char(tnid_pkg::CH_SPACE, random_bytes());
          tnid_pkg::IND_MIXED: begin
            repeat ($urandom_range(1, 5))
              add_char($urandom_range(0, 1) ? tnid_pkg::CH_TAB : tnid_pkg::CH_SPACE,
                       random_bytes());
          end
          default: ;
        endcase
        repeat ($urandom_range(0, 5)) add_char(body_char(), random_bytes());
        // The last line sometimes ends without a newline.
        if (l != lines - 1 || $urandom_range(99) < 90) add_line_end(nl_pref);
      end
    end
    send_doc();
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // LF, lone CR with a trailing CR that must not count, and CRLF with a tab line.
  task automatic test_line_endings();
    add_char(tnid_pkg::CP_W'("x"), 3'd1);
    add_char(tnid_pkg::CH_LF, 3'd1);
    add_char(tnid_pkg::CP_W'("y"), 3'd2);
    add_char(tnid_pkg::CH_LF, 3'd1);
    send_doc();

    add_char(tnid_pkg::CH_CR, 3'd1);
    add_char(tnid_pkg::CP_W'("a"), 3'd3);
    add_char(tnid_pkg::CH_CR, 3'd1);
    send_doc();

    add_char(tnid_pkg::CH_CR, 3'd1);
    add_char(tnid_pkg::CH_LF, 3'd1);
    add_char(tnid_pkg::CH_TAB, 3'd1);
    add_char(tnid_pkg::CP_W'("b"), 3'd4);
    add_char(tnid_pkg::CH_CR, 3'd1);
    add_char(tnid_pkg::CH_LF, 3'd1);
    send_doc();
  endtask

  // A space line, a mixed line, codepoint extremes and odd byte lengths.
  task automatic test_leading_whitespace();
    add_char(tnid_pkg::CH_SPACE, 3'd5);
    add_char(tnid_pkg::CH_SPACE, 3'd6);
    add_char('1, 3'd0);
    add_char(tnid_pkg::CH_LF, 3'd1);
    add_char(tnid_pkg::CH_SPACE, 3'd1);
    add_char(tnid_pkg::CH_TAB, 3'd1);
    add_char(tnid_pkg::CP_W'(1114111), 3'd7);
    add_char(tnid_pkg::CH_LF, 3'd4);
    send_doc();
  endtask

  // A NUL as the first character halts the scan; then a scan limit of one byte,
  // an indent override of three and a prior width of zero.
  task automatic test_scan_stop();
    add_char(tnid_pkg::CH_NUL, 3'd1);
    add_char(tnid_pkg::CP_W'("a"), 3'd1);
    add_char(tnid_pkg::CH_LF, 3'd1);
    send_doc();

    program_regs(25'd1, tnid_pkg::NL_CRLF, tnid_pkg::IND_MIXED, 8'd0, 8'd0);
    add_char(tnid_pkg::CP_W'("a"), 3'd5);
    add_char(tnid_pkg::CH_LF, 3'd6);
    add_char(tnid_pkg::CH_LF, 3'd1);
    send_doc();
  endtask

  task automatic test_register_overrides();
    program_regs(25'd16777216, tnid_pkg::NL_CR, tnid_pkg::IND_TAB, 8'd255, 8'd255);
    add_char(tnid_pkg::CH_SPACE, 3'd1);
    add_char(tnid_pkg::CP_W'("q"), 3'd1);
    add_char(tnid_pkg::CH_LF, 3'd1);
    send_doc();

    program_regs(25'd16777216, tnid_pkg::NL_LF, tnid_pkg::IND_SPACE, 8'd0, 8'd1);
    add_char(tnid_pkg::CP_W'("a"), 3'd1);
    add_char(tnid_pkg::CH_CR, 3'd1);
    send_doc();
  endtask

  // A run of more than 255 leading spaces must stick at the maximum, leaving the
  // minimum width at its start value instead of wrapping to a small run.
  task automatic test_long_indent();
    program_regs(25'd16777216, tnid_pkg::NL_AUTO, tnid_pkg::IND_NONE, 8'd0,
                 tnid_pkg::PRIOR_WIDTH_RESET);
    repeat (258) add_char(tnid_pkg::CH_SPACE, 3'd1);
    add_char(tnid_pkg::CP_W'("x"), 3'd1);
    add_char(tnid_pkg::CH_LF, 3'd1);
    send_doc();
  endtask

  task automatic program_random_config();
    logic [tnid_pkg::LIMIT_W-1:0] limit;
    int unsigned                  pick;
    pick = $urandom_range(99);
    if (pick < 60)      limit = tnid_pkg::SCAN_LIMIT_RESET;
    else if (pick < 80) limit = 25'd16777216;
    else                limit = tnid_pkg::LIMIT_W'($urandom_range(20, 200));
    program_regs(limit,
                 ($urandom_range(99) < 70) ? 2'd0 : 2'($urandom_range(0, 3)),
                 ($urandom_range(99) < 70) ? 2'd0 : 2'($urandom_range(0, 3)),
                 ($urandom_range(99) < 70) ? 8'd0 : 8'($urandom_range(0, 255)),
                 8'($urandom_range(1, 255)));
  endtask

  // Three register settings per idling mode, each run for a batch of documents.
  task automatic test_random_documents(int unsigned send_pct, int unsigned take_pct);
    int unsigned first;
    send_idle_pct = send_pct;
    take_idle_pct = take_pct;
    for (int seg = 0; seg < 3; seg++) begin
      program_random_config();
      first = chars_sent;
      while (chars_sent - first < SEG_CHARS) send_random_doc();
    end
  endtask

  initial begin
    clear_scan();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 10;
    take_idle_pct = 75;
    test_line_endings();
    test_leading_whitespace();
    test_scan_stop();
    test_register_overrides();
    test_long_indent();
    test_random_documents(10, 75);
    test_random_documents(75, 10);
    test_random_documents(0, 0);

    wait_drained();
    if (mismatches == 0) begin
      $display("text_newline_indent_detector verification clean");
    end else begin
      $display("text_newline_indent_detector verification failed");
    end
    $finish;
  end

endmodule

// ===== text_newline_indent_detector.f =====
sv/tnid_pkg.sv
sv/tnid_regs.sv
sv/tnid_scan.sv
sv/tnid_decide.sv
sv/text_newline_indent_detector.sv
dv/tb_text_newline_indent_detector.sv
